@@ rtl/assert_macros.svh @@
// Assertion macros used by the interrupt controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequence in the cycle after a trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pic_pkg.sv @@
// Types, codes and helper functions of the prioritized interrupt controller.
package pic_pkg;

  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_PIN    = 3'd2;
  localparam logic [2:0] CMD_RAISE  = 3'd3;
  localparam logic [2:0] CMD_ACK    = 3'd4;
  localparam logic [2:0] CMD_FINISH = 3'd5;

  localparam logic [5:0] OFF_PINS         = 6'h01;
  localparam logic [5:0] OFF_EDGE         = 6'h03;
  localparam logic [5:0] OFF_PLAIN_LOW    = 6'h05;
  localparam logic [5:0] OFF_ENABLE_A     = 6'h07;
  localparam logic [5:0] OFF_ENABLE_B     = 6'h09;
  localparam logic [5:0] OFF_PENDING_A    = 6'h0B;
  localparam logic [5:0] OFF_PENDING_B    = 6'h0D;
  localparam logic [5:0] OFF_IN_SERVICE_A = 6'h0F;
  localparam logic [5:0] OFF_IN_SERVICE_B = 6'h11;
  localparam logic [5:0] OFF_MASK_A       = 6'h13;
  localparam logic [5:0] OFF_MASK_B       = 6'h15;
  localparam logic [5:0] OFF_VECTOR       = 6'h17;
  localparam logic [5:0] OFF_PLAIN_FIRST  = 6'h19;
  localparam logic [5:0] OFF_PLAIN_LAST   = 6'h2F;

  localparam int         PLAIN_COUNT      = 13;
  localparam int         SOFT_EOI_BIT     = 3;
  localparam logic [7:0] VECTOR_RESET     = 8'h48;
  localparam logic [7:0] PIN_LEVELS_RESET = 8'hFF;

  typedef logic [$clog2(PLAIN_COUNT)-1:0] plain_idx_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] reg_offset;
    logic [7:0] write_data;
    logic [2:0] pin_index;
    logic       pin_level;
    logic [3:0] channel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ack_valid;
    logic [7:0] ack_vector;
    logic       irq_request;
    logic [3:0] pending_channel;
  } out_item_t;

  typedef struct packed {
    logic       found;
    logic [3:0] chan;
  } request_t;

  function automatic logic [3:0] pin_channel(logic [2:0] pin);
    logic [3:0] ch;
    case (pin)
      3'd0:    ch = 4'd0;
      3'd1:    ch = 4'd1;
      3'd2:    ch = 4'd2;
      3'd3:    ch = 4'd3;
      3'd4:    ch = 4'd6;
      3'd5:    ch = 4'd7;
      3'd6:    ch = 4'd14;
      default: ch = 4'd15;
    endcase
    return ch;
  endfunction

  function automatic request_t find_request(logic [15:0] pend, logic [15:0] serv);
    logic [15:0] held;
    logic [15:0] cand;
    request_t    r;
    for (int i = 0; i < 16; i++) begin
      held[i] = |(serv >> i);
    end
    cand    = pend & ~held;
    r.found = |cand;
    r.chan  = '0;
    for (int i = 0; i < 16; i++) begin
      if (cand[i]) begin
        r.chan = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/prioritized_interrupt_controller.sv @@
// Sixteen-channel prioritized interrupt controller with byte-wide registers.
// Each command item is captured in an input register, executed against the
// register state, and its result lands in a result register. The block takes
// one item every cycle unless the input stalls. The state update and both
// priority encodes (for the acknowledge and for the status after the
// command) fit between the input and result registers. The input stalls
// only while an item waits in the input register behind a result that is
// itself stalled.
`include "assert_macros.svh"

module prioritized_interrupt_controller
  import pic_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  logic       s1_valid;
  in_item_t   s1;
  logic       advance;

  logic [7:0]  pin_levels, pin_levels_next;
  logic [7:0]  edge_select, edge_select_next;
  logic [15:0] enable, enable_next;
  logic [15:0] pending, pending_next;
  logic [15:0] in_service, in_service_next;
  logic [15:0] mask, mask_next;
  logic [7:0]  vector_reg, vector_reg_next;
  logic [7:0]  plain_registers [PLAIN_COUNT];

  logic        plain_hit;
  logic [5:0]  plain_delta;
  plain_idx_t  plain_idx;
  logic        plain_we;
  logic [7:0]  read_mux;
  logic        raise;
  logic [3:0]  raise_chan;
  logic        pin_old;
  request_t    cur_req;
  request_t    nxt_req;
  out_item_t   result;

  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !advance;

  assign plain_delta = s1.reg_offset - OFF_PLAIN_FIRST;
  assign plain_hit   = (s1.reg_offset == OFF_PLAIN_LOW) ||
                       (s1.reg_offset >= OFF_PLAIN_FIRST && s1.reg_offset <= OFF_PLAIN_LAST &&
                        s1.reg_offset[0]);
  assign plain_idx   = (s1.reg_offset == OFF_PLAIN_LOW) ? '0 :
                       plain_idx_t'(plain_delta[5:1]) + plain_idx_t'(1);
  assign plain_we    = advance && (s1.cmd == CMD_WRITE) && plain_hit;

  always_comb begin
    read_mux = '0;
    if (plain_hit) begin
      read_mux = plain_registers[plain_idx];
    end else begin
      unique case (s1.reg_offset)
        OFF_PINS:         read_mux = pin_levels;
        OFF_EDGE:         read_mux = edge_select;
        OFF_ENABLE_A:     read_mux = enable[15:8];
        OFF_ENABLE_B:     read_mux = enable[7:0];
        OFF_PENDING_A:    read_mux = pending[15:8];
        OFF_PENDING_B:    read_mux = pending[7:0];
        OFF_IN_SERVICE_A: read_mux = in_service[15:8];
        OFF_IN_SERVICE_B: read_mux = in_service[7:0];
        OFF_MASK_A:       read_mux = mask[15:8];
        OFF_MASK_B:       read_mux = mask[7:0];
        OFF_VECTOR:       read_mux = vector_reg;
        default:          read_mux = '0;
      endcase
    end
  end

  always_comb begin
    pin_levels_next  = pin_levels;
    edge_select_next = edge_select;
    enable_next      = enable;
    pending_next     = pending;
    in_service_next  = in_service;
    mask_next        = mask;
    vector_reg_next  = vector_reg;
    raise            = 1'b0;
    raise_chan       = s1.channel;
    pin_old          = pin_levels[s1.pin_index];
    cur_req          = find_request(pending & mask, in_service);
    result           = '0;

    case (s1.cmd)
      CMD_READ: begin
        result.read_data = read_mux;
      end
      CMD_WRITE: begin
        if (!plain_hit) begin
          unique case (s1.reg_offset)
            OFF_EDGE: edge_select_next = s1.write_data;
            OFF_ENABLE_A: begin
              enable_next[15:8]  = s1.write_data;
              pending_next[15:8] = pending[15:8] & s1.write_data;
            end
            OFF_ENABLE_B: begin
              enable_next[7:0]  = s1.write_data;
              pending_next[7:0] = pending[7:0] & s1.write_data;
            end
            OFF_PENDING_A:    pending_next[15:8]    = pending[15:8] & s1.write_data;
            OFF_PENDING_B:    pending_next[7:0]     = pending[7:0] & s1.write_data;
            OFF_IN_SERVICE_A: in_service_next[15:8] = in_service[15:8] & s1.write_data;
            OFF_IN_SERVICE_B: in_service_next[7:0]  = in_service[7:0] & s1.write_data;
            OFF_MASK_A:       mask_next[15:8]       = s1.write_data;
            OFF_MASK_B:       mask_next[7:0]        = s1.write_data;
            OFF_VECTOR: begin
              vector_reg_next = s1.write_data;
              if (!s1.write_data[SOFT_EOI_BIT]) begin
                in_service_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_PIN: begin
        pin_levels_next[s1.pin_index] = s1.pin_level;
        raise      = (pin_old != s1.pin_level) &&
                     (edge_select[s1.pin_index] == s1.pin_level);
        raise_chan = pin_channel(s1.pin_index);
      end
      CMD_RAISE: begin
        raise = 1'b1;
      end
      CMD_ACK: begin
        if (cur_req.found) begin
          pending_next[cur_req.chan] = 1'b0;
          if (vector_reg[SOFT_EOI_BIT]) begin
            in_service_next[cur_req.chan] = 1'b1;
          end
          result.ack_valid  = 1'b1;
          result.ack_vector = {vector_reg[7:4], cur_req.chan};
        end
      end
      CMD_FINISH: begin
        in_service_next[s1.channel] = 1'b0;
      end
      default: ;
    endcase

    if (raise && enable[raise_chan]) begin
      pending_next[raise_chan] = 1'b1;
    end

    nxt_req                = find_request(pending_next & mask_next, in_service_next);
    result.irq_request     = nxt_req.found;
    result.pending_channel = nxt_req.found ? nxt_req.chan : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1 <= req;
    end
    if (advance) begin
      rsp <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_levels  <= PIN_LEVELS_RESET;
      edge_select <= '0;
      enable      <= '0;
      pending     <= '0;
      in_service  <= '0;
      mask        <= '0;
      vector_reg  <= VECTOR_RESET;
      for (int i = 0; i < PLAIN_COUNT; i++) begin
        plain_registers[i] <= '0;
      end
    end else begin
      if (advance) begin
        pin_levels  <= pin_levels_next;
        edge_select <= edge_select_next;
        enable      <= enable_next;
        pending     <= pending_next;
        in_service  <= in_service_next;
        mask        <= mask_next;
        vector_reg  <= vector_reg_next;
      end
      if (plain_we) begin
        plain_registers[plain_idx] <= s1.write_data;
      end
    end
  end

  `ASSERT_ALWAYS(a_pend_enabled, (pending & ~enable) == '0, "pending on disabled channel")
  `ASSERT_NEXT(a_s1_hold, s1_valid && !advance, s1_valid && $stable(s1), "held item changed")
  `ASSERT_ALWAYS(a_ack_no_read, !rsp_valid || !rsp.ack_valid || ~|rsp.read_data, "ack with data")
  `ASSERT_ALWAYS(a_idle_chan, !rsp_valid || rsp.irq_request || ~|rsp.pending_channel, "idle channel")

endmodule

@@ test/prioritized_interrupt_controller_tb.sv @@
`timescale 1ns / 1ps
// Testbench of the prioritized interrupt controller: directed and random commands against a predictor.
module prioritized_interrupt_controller_tb;
  import pic_pkg::*;

  localparam logic [2:0]  CMD_SPARE_LOW  = 3'd6;
  localparam logic [2:0]  CMD_SPARE_HIGH = 3'd7;
  localparam logic [5:0]  OFF_NONE_LOW   = 6'h00;
  localparam logic [5:0]  OFF_NONE_HIGH  = 6'h3F;
  localparam logic [31:0] PIN_WIRING     = {4'd15, 4'd14, 4'd7, 4'd6, 4'd3, 4'd2, 4'd1, 4'd0};
  localparam int          IDLE_PERCENT   = 16;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          DRAIN_CYCLES   = 10;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  in_item_t  req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  out_item_t rsp;

  logic      idle_on = 1'b1;
  logic      hold_on = 1'b0;
  int        mismatches = 0;
  int        results_seen = 0;
  out_item_t expected_results[$];
  out_item_t oldest;

  logic [7:0] pin_state, edge_sel, vec_reg;
  logic [7:0] en_hi, en_lo, pend_hi, pend_lo, isr_hi, isr_lo, mask_hi, mask_lo;
  logic [7:0] plain_regs [PLAIN_COUNT];

  prioritized_interrupt_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_model();
    pin_state = PIN_LEVELS_RESET;
    edge_sel  = '0;
    vec_reg   = VECTOR_RESET;
    en_hi     = '0;
    en_lo     = '0;
    pend_hi   = '0;
    pend_lo   = '0;
    isr_hi    = '0;
    isr_lo    = '0;
    mask_hi   = '0;
    mask_lo   = '0;
    for (int i = 0; i < PLAIN_COUNT; i++) begin
      plain_regs[i] = '0;
    end
  endfunction

  function automatic int plain_slot(logic [5:0] off);
    int slot;
    slot = -1;
    if (off == OFF_PLAIN_LOW) begin
      slot = 0;
    end else if (off >= OFF_PLAIN_FIRST && off <= OFF_PLAIN_LAST && off[0]) begin
      slot = 1 + ((int'(off) - int'(OFF_PLAIN_FIRST)) >> 1);
    end
    return slot;
  endfunction

  // {found, channel} of the highest channel allowed to request service
  function automatic logic [4:0] highest_request();
    logic [15:0] pend;
    logic [15:0] serv;
    logic [4:0]  pick;
    pend = {pend_hi & mask_hi, pend_lo & mask_lo};
    serv = {isr_hi, isr_lo};
    pick = '0;
    for (int c = 15; c >= 0; c--) begin
      if (serv[c]) break;
      if (pend[c]) begin
        pick = {1'b1, 4'(c)};
        break;
      end
    end
    return pick;
  endfunction

  function automatic void raise_channel(logic [3:0] ch);
    if (ch[3]) begin
      if (en_hi[ch[2:0]]) pend_hi[ch[2:0]] = 1'b1;
    end else begin
      if (en_lo[ch[2:0]]) pend_lo[ch[2:0]] = 1'b1;
    end
  endfunction

  function automatic logic [7:0] read_register(logic [5:0] off);
    logic [7:0] v;
    int         slot;
    slot = plain_slot(off);
    if (slot >= 0) begin
      v = plain_regs[slot];
    end else begin
      case (off)
        OFF_PINS:         v = pin_state;
        OFF_EDGE:         v = edge_sel;
        OFF_ENABLE_A:     v = en_hi;
        OFF_ENABLE_B:     v = en_lo;
        OFF_PENDING_A:    v = pend_hi;
        OFF_PENDING_B:    v = pend_lo;
        OFF_IN_SERVICE_A: v = isr_hi;
        OFF_IN_SERVICE_B: v = isr_lo;
        OFF_MASK_A:       v = mask_hi;
        OFF_MASK_B:       v = mask_lo;
        OFF_VECTOR:       v = vec_reg;
        default:          v = '0;
      endcase
    end
    return v;
  endfunction

  function automatic void write_register(logic [5:0] off, logic [7:0] v);
    int slot;
    slot = plain_slot(off);
    if (slot >= 0) begin
      plain_regs[slot] = v;
    end else begin
      case (off)
        OFF_EDGE:         edge_sel = v;
        OFF_ENABLE_A: begin
          en_hi   = v;
          pend_hi = pend_hi & v;
        end
        OFF_ENABLE_B: begin
          en_lo   = v;
          pend_lo = pend_lo & v;
        end
        OFF_PENDING_A:    pend_hi = pend_hi & v;
        OFF_PENDING_B:    pend_lo = pend_lo & v;
        OFF_IN_SERVICE_A: isr_hi = isr_hi & v;
        OFF_IN_SERVICE_B: isr_lo = isr_lo & v;
        OFF_MASK_A:       mask_hi = v;
        OFF_MASK_B:       mask_lo = v;
        OFF_VECTOR: begin
          vec_reg = v;
          if (!v[SOFT_EOI_BIT]) begin
            isr_hi = '0;
            isr_lo = '0;
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t  res;
    logic [4:0] pick;
    logic       was;
    res = '0;
    case (it.cmd)
      CMD_READ:  res.read_data = read_register(it.reg_offset);
      CMD_WRITE: write_register(it.reg_offset, it.write_data);
      CMD_PIN: begin
        was = pin_state[it.pin_index];
        pin_state[it.pin_index] = it.pin_level;
        if (was != it.pin_level && edge_sel[it.pin_index] == it.pin_level) begin
          raise_channel(PIN_WIRING[{it.pin_index, 2'b00} +: 4]);
        end
      end
      CMD_RAISE: raise_channel(it.channel);
      CMD_ACK: begin
        pick = highest_request();
        if (pick[4]) begin
          if (pick[3]) begin
            pend_hi[pick[2:0]] = 1'b0;
            if (vec_reg[SOFT_EOI_BIT]) isr_hi[pick[2:0]] = 1'b1;
          end else begin
            pend_lo[pick[2:0]] = 1'b0;
            if (vec_reg[SOFT_EOI_BIT]) isr_lo[pick[2:0]] = 1'b1;
          end
          res.ack_valid  = 1'b1;
          res.ack_vector = {vec_reg[7:4], pick[3:0]};
        end
      end
      CMD_FINISH: begin
        if (it.channel[3]) begin
          isr_hi[it.channel[2:0]] = 1'b0;
        end else begin
          isr_lo[it.channel[2:0]] = 1'b0;
        end
      end
      default: ;
    endcase
    pick = highest_request();
    res.irq_request     = pick[4];
    res.pending_channel = pick[3:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  task automatic send_command(input in_item_t item);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_results.push_back(predict_result(item));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          oldest = expected_results.pop_front();
          compare_field("read_data", rsp.read_data, oldest.read_data);
          compare_field("ack_valid", 8'(rsp.ack_valid), 8'(oldest.ack_valid));
          compare_field("ack_vector", rsp.ack_vector, oldest.ack_vector);
          compare_field("irq_request", 8'(rsp.irq_request), 8'(oldest.irq_request));
          compare_field("pending_channel", 8'(rsp.pending_channel), 8'(oldest.pending_channel));
        end
      end
      rsp_stall <= hold_on || (idle_on && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  function automatic in_item_t make_item(logic [2:0] cmd, logic [5:0] off, logic [7:0] data,
                                         logic [2:0] pin, logic level, logic [3:0] ch);
    in_item_t it;
    it.cmd        = cmd;
    it.reg_offset = off;
    it.write_data = data;
    it.pin_index  = pin;
    it.pin_level  = level;
    it.channel    = ch;
    return it;
  endfunction

  function automatic logic [5:0] random_mapped_offset();
    return 6'(2 * $urandom_range(23) + 1);
  endfunction

  function automatic in_item_t random_command();
    in_item_t it;
    int       pick;
    it.reg_offset = 6'($urandom_range(63));
    it.write_data = 8'($urandom_range(255));
    it.pin_index  = 3'($urandom_range(7));
    it.pin_level  = 1'($urandom_range(1));
    it.channel    = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 25) begin
      it.cmd = CMD_RAISE;
    end else if (pick < 45) begin
      it.cmd = CMD_ACK;
    end else if (pick < 55) begin
      it.cmd = CMD_FINISH;
    end else if (pick < 70) begin
      it.cmd = CMD_PIN;
    end else if (pick < 85) begin
      it.cmd = CMD_WRITE;
      case ($urandom_range(15))
        0, 1:    it.reg_offset = OFF_ENABLE_A;
        2, 3:    it.reg_offset = OFF_ENABLE_B;
        4:       it.reg_offset = OFF_MASK_A;
        5:       it.reg_offset = OFF_MASK_B;
        6:       it.reg_offset = OFF_VECTOR;
        7:       it.reg_offset = OFF_EDGE;
        8:       it.reg_offset = OFF_PENDING_A;
        9:       it.reg_offset = OFF_PENDING_B;
        10:      it.reg_offset = OFF_IN_SERVICE_A;
        11:      it.reg_offset = OFF_IN_SERVICE_B;
        12, 13:  it.reg_offset = random_mapped_offset();
        default: ;
      endcase
    end else if (pick < 97) begin
      it.cmd = CMD_READ;
      if ($urandom_range(9) < 7) it.reg_offset = random_mapped_offset();
    end else begin
      it.cmd = $urandom_range(1) ? CMD_SPARE_HIGH : CMD_SPARE_LOW;
    end
    return it;
  endfunction

  task automatic test_register_access();
    send_command(make_item(CMD_READ, OFF_PINS, 8'h00, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_WRITE, OFF_PINS, 8'h00, 3'd7, 1'b1, 4'd15));
    send_command(make_item(CMD_READ, OFF_PINS, 8'hFF, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_READ, OFF_VECTOR, 8'h00, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_WRITE, OFF_PLAIN_LAST, 8'hFF, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_READ, OFF_PLAIN_LAST, 8'h00, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_WRITE, OFF_NONE_HIGH, 8'hFF, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_READ, OFF_NONE_HIGH, 8'h00, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_READ, OFF_NONE_LOW, 8'h00, 3'd0, 1'b0, 4'd0));
  endtask

  task automatic test_interrupt_flow();
    // drop a raise on a disabled channel
    send_command(make_item(CMD_RAISE, OFF_NONE_LOW, 8'h00, 3'd0, 1'b0, 4'd15));
    send_command(make_item(CMD_WRITE, OFF_ENABLE_A, 8'hFF, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_WRITE, OFF_ENABLE_B, 8'hFF, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_RAISE, OFF_NONE_LOW, 8'h00, 3'd0, 1'b0, 4'd15));
    send_command(make_item(CMD_WRITE, OFF_MASK_A, 8'hFF, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_RAISE, OFF_NONE_LOW, 8'h00, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_WRITE, OFF_MASK_B, 8'hFF, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_ACK, OFF_NONE_LOW, 8'h00, 3'd0, 1'b0, 4'd0));
    // hold off everything below the channel in service
    send_command(make_item(CMD_ACK, OFF_NONE_LOW, 8'h00, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_FINISH, OFF_NONE_LOW, 8'h00, 3'd0, 1'b0, 4'd15));
    send_command(make_item(CMD_WRITE, OFF_PENDING_B, 8'h00, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_PIN, OFF_NONE_LOW, 8'h00, 3'd7, 1'b0, 4'd0));
    send_command(make_item(CMD_PIN, OFF_NONE_LOW, 8'h00, 3'd7, 1'b0, 4'd0));
    send_command(make_item(CMD_WRITE, OFF_ENABLE_A, 8'h00, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_WRITE, OFF_EDGE, 8'hFF, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_PIN, OFF_NONE_LOW, 8'h00, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_PIN, OFF_NONE_LOW, 8'h00, 3'd0, 1'b1, 4'd0));
    send_command(make_item(CMD_ACK, OFF_NONE_LOW, 8'h00, 3'd0, 1'b0, 4'd0));
    // clear all in-service bits through the vector register
    send_command(make_item(CMD_WRITE, OFF_VECTOR, 8'hF0, 3'd0, 1'b0, 4'd0));
    send_command(make_item(CMD_SPARE_LOW, OFF_NONE_HIGH, 8'hFF, 3'd7, 1'b1, 4'd15));
    send_command(make_item(CMD_SPARE_HIGH, OFF_NONE_HIGH, 8'hFF, 3'd7, 1'b1, 4'd15));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_command(random_command());
  endtask

  task automatic test_steady_stream(input int count);
    idle_on <= 1'b0;
    repeat (count) send_command(random_command());
    idle_on <= 1'b1;
  endtask

  task automatic test_backpressure();
    hold_on <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    repeat (40) send_command(random_command());
  endtask

  initial begin
    clear_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_interrupt_flow();
    test_random_traffic(600);
    test_steady_stream(200);
    test_backpressure();
    test_random_traffic(300);
    req_valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pic_pkg.sv
rtl/prioritized_interrupt_controller.sv
test/prioritized_interrupt_controller_tb.sv
